/* rtl/ddawc_pkg.sv */
// Shared types, constants and saturation helper for the differential drive
// wheel controller. No dependencies; the lane, command unit and top-level files import it.
package ddawc_pkg;

  // Operation codes of an input item.
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASIS  = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;

  // Reset values of the configuration registers (unsigned Q0.16).
  localparam logic [15:0] BASIS_RESET  = 16'd4096;
  localparam logic [15:0] RADIUS_RESET = 16'd1835;

  // Gain steps in Q4.12.
  localparam logic signed [16:0] GAIN_STEP_UP    = 17'sd41;
  localparam logic signed [16:0] GAIN_STEP_DOWN  = -17'sd41;
  localparam logic signed [16:0] GAIN_STEP_STILL = 17'sd205;

  // Half-LSB rounding offsets for the two narrowing shifts.
  localparam logic signed [33:0] ROUND_EFFORT = 34'sd2048;
  localparam logic signed [33:0] ROUND_DELTA  = 34'sd32768;

  // Controls from the sequencer to one wheel lane.
  typedef struct packed {
    logic meas_load;
    logic gain_load;
    logic prod_load;
  } lane_ctrl_t;

  // Controls from the sequencer to the command unit.
  typedef struct packed {
    logic prod_load;
    logic target_load;
  } cmd_ctrl_t;

  // Clamp a wide signed value to the 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ddawc_if.sv */
// Valid/ready channel interfaces for input items and results.
// Depends on nothing; payload widths follow the item fields.
interface ddawc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] linear_speed;
  logic signed [15:0] turn_rate;
  logic signed [15:0] left_joint_rate;
  logic signed [15:0] right_joint_rate;

  modport source (output valid, output operation, output linear_speed, output turn_rate,
                  output left_joint_rate, output right_joint_rate, input ready);
  modport sink   (input valid, input operation, input linear_speed, input turn_rate,
                  input left_joint_rate, input right_joint_rate, output ready);
endinterface

interface ddawc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_effort;
  logic signed [15:0] right_effort;

  modport source (output valid, output left_effort, output right_effort, input ready);
  modport sink   (input valid, input left_effort, input right_effort, output ready);
endinterface

/* rtl/ddawc_lane.sv */
// One wheel lane: measured speed, adaptive gain update and effort product.
// Depends on ddawc_pkg for the control struct, gain steps and saturation.
module ddawc_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  ddawc_pkg::lane_ctrl_t ctrl,
  input  logic signed [15:0]    joint_rate,
  input  logic [15:0]           radius,
  input  logic signed [15:0]    target,
  output logic signed [15:0]    effort
);
  import ddawc_pkg::*;

  logic signed [32:0] meas;
  logic signed [15:0] gain;
  logic signed [15:0] gain_next;
  logic signed [31:0] prod;
  logic signed [32:0] tgt_wide;
  logic signed [16:0] step;
  logic signed [16:0] gain_sum;
  logic signed [33:0] prod_rnd;
  logic signed [33:0] prod_shift;
  logic               above;

  // Measured speed in Q8.24, exact.
  always_ff @(posedge clk) begin
    if (ctrl.meas_load) begin
      meas <= 33'(joint_rate) * 33'($signed({1'b0, radius}));
    end
  end

  // Ratio test by sign: compare target with measured speed in Q8.24.
  always_comb begin
    tgt_wide = $signed({target[15], target, 16'd0});
    above    = meas[32] ? (tgt_wide < meas) : (tgt_wide > meas);
    if (meas != 33'sd0) begin
      step = above ? GAIN_STEP_UP : GAIN_STEP_DOWN;
    end else if (target != 16'sd0) begin
      step = GAIN_STEP_STILL;
    end else begin
      step = 17'sd0;
    end
    gain_sum  = $signed({gain[15], gain}) + step;
    gain_next = sat16($signed({{17{gain_sum[16]}}, gain_sum}));
  end

  // Gain state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (ctrl.gain_load) begin
      gain <= gain_next;
    end
  end

  // Effort product in Q12.20 with the updated gain.
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod <= 32'(target) * 32'(gain);
    end
  end

  // Round to Q8.8 and saturate.
  always_comb begin
    prod_rnd   = $signed({{2{prod[31]}}, prod}) + ROUND_EFFORT;
    prod_shift = prod_rnd >>> 12;
    effort     = sat16(prod_shift);
  end

endmodule

/* rtl/ddawc_cmd.sv */
// Command unit: turns forward speed and turn rate into two wheel targets.
// Depends on ddawc_pkg for the control struct, rounding and saturation.
module ddawc_cmd (
  input  logic                 clk,
  input  logic                 rst,
  input  ddawc_pkg::cmd_ctrl_t ctrl,
  input  logic signed [15:0]   linear_speed,
  input  logic signed [15:0]   turn_rate,
  input  logic [15:0]          basis,
  output logic signed [15:0]   left_target,
  output logic signed [15:0]   right_target
);
  import ddawc_pkg::*;

  logic signed [32:0] prod;
  logic signed [15:0] linear;
  logic signed [33:0] prod_rnd;
  logic signed [33:0] delta;
  logic signed [33:0] lin_wide;

  // Turn term in Q8.24 and the forward speed, captured on transfer.
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod   <= 33'(turn_rate) * 33'($signed({1'b0, basis}));
      linear <= linear_speed;
    end
  end

  // Round the turn term to Q8.8.
  always_comb begin
    prod_rnd = $signed({prod[32], prod}) + ROUND_DELTA;
    delta    = prod_rnd >>> 16;
    lin_wide = $signed({{18{linear[15]}}, linear});
  end

  // Target state.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_target  <= '0;
      right_target <= '0;
    end else if (ctrl.target_load) begin
      left_target  <= sat16(lin_wide - delta);
      right_target <= sat16(lin_wide + delta);
    end
  end

endmodule

/* rtl/diff_drive_adaptive_wheel_control.sv */
// Differential drive wheel controller with adaptive per-wheel gains.
// Takes one item at a time. A command updates the targets before the next
// ready; a measurement passes through multiply, gain update, effort product
// and output register, which waits for a held result to be taken. Two wheel
// lanes run side by side. Synchronous active-high reset restores the
// basis and radius defaults and clears targets, gains and the result.
module diff_drive_adaptive_wheel_control (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  ddawc_in_if.sink    item,
  ddawc_out_if.source result
);
  import ddawc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_ADAPT = 3'd2;
  localparam logic [2:0] S_EFF   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [15:0]        track_width;
  logic [15:0]        tire_size;
  logic               take;
  logic               out_load;
  lane_ctrl_t         lane_ctrl;
  cmd_ctrl_t          cmd_ctrl;
  logic signed [15:0] left_target;
  logic signed [15:0] right_target;
  logic signed [15:0] left_lane_effort;
  logic signed [15:0] right_lane_effort;
  logic               out_valid;
  logic signed [15:0] left_effort;
  logic signed [15:0] right_effort;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      track_width <= BASIS_RESET;
      tire_size   <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASIS:  track_width <= cfg_data;
        REG_RADIUS: tire_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.ready = (state == S_IDLE);
  assign take       = item.valid && item.ready;
  assign out_load   = (state == S_OUT) && (!out_valid || result.ready);

  // Sequencer.
  always_comb begin
    state_next          = state;
    lane_ctrl           = '0;
    cmd_ctrl            = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (item.operation == OP_MEASURE) begin
            lane_ctrl.meas_load = 1'b1;
            state_next          = S_ADAPT;
          end else begin
            cmd_ctrl.prod_load = 1'b1;
            state_next         = S_CMD;
          end
        end
      end
      S_CMD: begin
        cmd_ctrl.target_load = 1'b1;
        state_next           = S_IDLE;
      end
      S_ADAPT: begin
        lane_ctrl.gain_load = 1'b1;
        state_next          = S_EFF;
      end
      S_EFF: begin
        lane_ctrl.prod_load = 1'b1;
        state_next          = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  ddawc_cmd u_cmd (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (cmd_ctrl),
    .linear_speed (item.linear_speed),
    .turn_rate    (item.turn_rate),
    .basis        (track_width),
    .left_target  (left_target),
    .right_target (right_target)
  );

  ddawc_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .joint_rate (item.left_joint_rate),
    .radius     (tire_size),
    .target     (left_target),
    .effort     (left_lane_effort)
  );

  ddawc_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .joint_rate (item.right_joint_rate),
    .radius     (tire_size),
    .target     (right_target),
    .effort     (right_lane_effort)
  );

  // Merge both lanes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_effort  <= left_lane_effort;
      right_effort <= right_lane_effort;
    end
  end

  assign result.valid        = out_valid;
  assign result.left_effort  = left_effort;
  assign result.right_effort = right_effort;

endmodule
